>>> src/assert_macros.svh
// Assertion macros shared by the servo-bus deframer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the given active-low reset is asserted.
`define SBPD_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");

// Same, on the house clock and reset names.
`define SBPD_ASSERT(lbl, prop) \
    `SBPD_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

>>> src/sbpd_pkg.sv
// Package for the servo-bus packet deframer: result type and frame constants.
// No dependencies.
package sbpd_pkg;

    localparam int          IDX_W    = 6;
    localparam logic [7:0]  HDR_BYTE = 8'hFF;
    localparam logic [7:0]  CHK_MASK = 8'hFE;
    localparam logic [7:0]  MIN_LEN  = 8'd7;

    typedef struct packed {
        logic             data_valid;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] data_index;
        logic             packet_end;
        logic [7:0]       packet_id;
        logic [7:0]       command;
        logic [7:0]       packet_size;
        logic [7:0]       stat_err;
        logic [7:0]       stat_info;
        logic             checksum_ok;
        logic             data_overflow;
        logic             length_error;
    } t_result;

endpackage

>>> src/sbpd_if.sv
// Handshake channels of the servo-bus packet deframer: byte in, result out.
// No dependencies.
interface sbpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbpd_out_if;
    logic       valid;
    logic       ready;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [5:0] data_index;
    logic       packet_end;
    logic [7:0] packet_id;
    logic [7:0] command;
    logic [7:0] packet_size;
    logic [7:0] stat_err;
    logic [7:0] stat_info;
    logic       checksum_ok;
    logic       data_overflow;
    logic       length_error;

    modport source (
        output valid, output data_valid, output data_byte, output data_index,
        output packet_end, output packet_id, output command, output packet_size,
        output stat_err, output stat_info, output checksum_ok,
        output data_overflow, output length_error, input ready
    );
    modport sink (
        input valid, input data_valid, input data_byte, input data_index,
        input packet_end, input packet_id, input command, input packet_size,
        input stat_err, input stat_info, input checksum_ok,
        input data_overflow, input length_error, output ready
    );
endinterface

>>> src/servo_bus_packet_deframer.sv
// Servo-bus packet deframer, top level.
// Depends on sbpd_pkg, sbpd_if, sbpd_parser and sbpd_obuf.
//
// Takes one received byte per transfer on i_in and hunts for the 0xFF 0xFF
// header, then captures length, id, command and the two check bytes, then the
// payload. Each payload byte within the first MAX_DATA gives a result at once
// (data_valid, data_byte, data_index modulo 64); the byte that brings the
// packet count up to the length field also marks packet_end and carries id,
// command, size, any last two payload bytes as status, the checksum verdict
// and the overflow flag. A length field below seven gives a lone result with
// length_error set and abandons the packet. Bytes that close nothing (header,
// fields, check bytes, dropped overflow bytes) give no result. One byte is
// accepted every clock: the parser state updates in a single pass of compare
// and XOR logic, and results land in a two-entry output buffer, so i_in.ready
// only drops when both the output register and the skid register are full.
// A result reaches o_out through the output buffer's registers.
module servo_bus_packet_deframer
    import sbpd_pkg::*;
#(
    parameter int MAX_DATA = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sbpd_in_if.sink           i_in,
    sbpd_out_if.source        o_out
);

    logic    w_accept;
    logic    w_ready;
    logic    w_res_valid;
    t_result w_res;
    logic    w_out_valid;
    t_result w_out;

    // A transfer on the input: byte enters the parser this edge
    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;

    sbpd_parser #(
        .MAX_DATA (MAX_DATA)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_in.rx_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    sbpd_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res_valid),
        .i_data      (w_res),
        .i_out_ready (o_out.ready),
        .o_ready     (w_ready),
        .o_valid     (w_out_valid),
        .o_data      (w_out)
    );

    // Drive the output channel from the buffered result
    assign o_out.valid         = w_out_valid;
    assign o_out.data_valid    = w_out.data_valid;
    assign o_out.data_byte     = w_out.data_byte;
    assign o_out.data_index    = w_out.data_index;
    assign o_out.packet_end    = w_out.packet_end;
    assign o_out.packet_id     = w_out.packet_id;
    assign o_out.command       = w_out.command;
    assign o_out.packet_size   = w_out.packet_size;
    assign o_out.stat_err      = w_out.stat_err;
    assign o_out.stat_info     = w_out.stat_info;
    assign o_out.checksum_ok   = w_out.checksum_ok;
    assign o_out.data_overflow = w_out.data_overflow;
    assign o_out.length_error  = w_out.length_error;

endmodule

>>> src/sbpd_parser.sv
// Frame parser: header hunt, field capture, checksum and payload tracking.
// Depends on sbpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sbpd_parser
    import sbpd_pkg::*;
#(
    parameter int MAX_DATA = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam logic [7:0] MaxData = 8'(MAX_DATA);

    typedef enum logic [2:0] {
        PH_HDR1, PH_HDR2, PH_LEN, PH_ID, PH_CMD, PH_CK1, PH_CK2, PH_DATA
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_seen,  n_seen;
    logic [7:0] r_xor,   n_xor;
    logic [7:0] r_len,   n_len;
    logic [7:0] r_id,    n_id;
    logic [7:0] r_cmd,   n_cmd;
    logic [7:0] r_ck1,   n_ck1;
    logic [7:0] r_ck2,   n_ck2;
    logic [7:0] r_pcount, n_pcount;
    logic [7:0] r_prev,  n_prev;
    logic       r_ovf,   n_ovf;

    logic [7:0] w_xor_upd;
    logic [7:0] w_c1, w_c2;
    logic       w_stored;

    // Check values from the updated running XOR
    assign w_xor_upd = (r_phase == PH_DATA) ? (r_xor ^ i_byte) : r_xor;
    assign w_c1      = w_xor_upd & CHK_MASK;
    assign w_c2      = (~w_c1) & CHK_MASK;
    assign w_stored  = (r_pcount < MaxData);

    always_comb begin
        n_phase  = r_phase;
        n_seen   = r_seen;
        n_xor    = r_xor;
        n_len    = r_len;
        n_id     = r_id;
        n_cmd    = r_cmd;
        n_ck1    = r_ck1;
        n_ck2    = r_ck2;
        n_pcount = r_pcount;
        n_prev   = r_prev;
        n_ovf    = r_ovf;
        o_res       = '0;
        o_res_valid = 1'b0;
        if (i_accept) begin
            unique case (r_phase)
                PH_HDR1: begin
                    if (i_byte == HDR_BYTE) n_phase = PH_HDR2;
                end
                PH_HDR2: begin
                    n_phase = (i_byte == HDR_BYTE) ? PH_LEN : PH_HDR1;
                end
                PH_LEN: begin
                    n_len = i_byte;
                    if (i_byte < MIN_LEN) begin
                        // Short length: report and drop the packet
                        o_res.packet_size  = i_byte;
                        o_res.length_error = 1'b1;
                        o_res_valid        = 1'b1;
                        n_phase            = PH_HDR1;
                    end else begin
                        n_xor    = i_byte;
                        n_seen   = 8'd3;
                        n_pcount = '0;
                        n_prev   = '0;
                        n_ovf    = 1'b0;
                        n_id     = '0;
                        n_cmd    = '0;
                        n_ck1    = '0;
                        n_ck2    = '0;
                        n_phase  = PH_ID;
                    end
                end
                PH_ID: begin
                    n_id    = i_byte;
                    n_xor   = r_xor ^ i_byte;
                    n_seen  = r_seen + 8'd1;
                    n_phase = PH_CMD;
                end
                PH_CMD: begin
                    n_cmd   = i_byte;
                    n_xor   = r_xor ^ i_byte;
                    n_seen  = r_seen + 8'd1;
                    n_phase = PH_CK1;
                end
                PH_CK1: begin
                    n_ck1   = i_byte;
                    n_seen  = r_seen + 8'd1;
                    n_phase = PH_CK2;
                end
                PH_CK2: begin
                    n_ck2  = i_byte;
                    n_seen = r_seen + 8'd1;
                    if (n_seen >= r_len) begin
                        // No payload: close the packet here
                        o_res.packet_end    = 1'b1;
                        o_res.packet_id     = r_id;
                        o_res.command       = r_cmd;
                        o_res.packet_size   = r_len;
                        o_res.checksum_ok   = (w_c1 == r_ck1) && (w_c2 == i_byte);
                        o_res.data_overflow = r_ovf;
                        o_res_valid         = 1'b1;
                        n_phase             = PH_HDR1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (w_stored) begin
                        o_res.data_valid = 1'b1;
                        o_res.data_byte  = i_byte;
                        o_res.data_index = r_pcount[IDX_W-1:0];
                        o_res_valid      = 1'b1;
                    end
                    n_ovf    = r_ovf | ~w_stored;
                    n_xor    = r_xor ^ i_byte;
                    n_pcount = (r_pcount == 8'hFF) ? r_pcount : r_pcount + 8'd1;
                    n_seen   = r_seen + 8'd1;
                    n_prev   = i_byte;
                    if (n_seen >= r_len) begin
                        o_res.packet_end    = 1'b1;
                        o_res.packet_id     = r_id;
                        o_res.command       = r_cmd;
                        o_res.packet_size   = r_len;
                        if (n_pcount >= 8'd2) begin
                            o_res.stat_err  = r_prev;
                            o_res.stat_info = i_byte;
                        end
                        o_res.checksum_ok   = (w_c1 == r_ck1) && (w_c2 == r_ck2);
                        o_res.data_overflow = n_ovf;
                        o_res_valid         = 1'b1;
                        n_phase             = PH_HDR1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR1;
            r_seen   <= '0;
            r_xor    <= '0;
            r_len    <= '0;
            r_id     <= '0;
            r_cmd    <= '0;
            r_ck1    <= '0;
            r_ck2    <= '0;
            r_pcount <= '0;
            r_prev   <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_seen   <= n_seen;
            r_xor    <= n_xor;
            r_len    <= n_len;
            r_id     <= n_id;
            r_cmd    <= n_cmd;
            r_ck1    <= n_ck1;
            r_ck2    <= n_ck2;
            r_pcount <= n_pcount;
            r_prev   <= n_prev;
            r_ovf    <= n_ovf;
        end
    end

    `SBPD_ASSERT(a_len_err_alone,
        o_res_valid && o_res.length_error |-> !o_res.data_valid && !o_res.packet_end)
    `SBPD_ASSERT(a_end_rehunts, o_res_valid && o_res.packet_end |=> r_phase == PH_HDR1)
    `SBPD_ASSERT(a_broken_header,
        i_accept && r_phase == PH_HDR2 && i_byte != HDR_BYTE |=> r_phase == PH_HDR1)

endmodule

>>> src/sbpd_obuf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on sbpd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sbpd_obuf
    import sbpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_out_ready,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data
);

    logic    r_main_valid, r_skid_valid;
    t_result r_main, r_skid;
    logic    w_pop, w_load_main;

    assign w_pop       = r_main_valid && i_out_ready;
    assign w_load_main = !r_main_valid || w_pop;
    assign o_ready     = !r_skid_valid;
    assign o_valid     = r_main_valid;
    assign o_data      = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_load_main) begin
            r_main_valid <= r_skid_valid | i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Hold payload; advance skid into the output register first
    always_ff @(posedge i_clk) begin
        if (w_load_main) begin
            r_main <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    `SBPD_ASSERT(a_skid_behind_main, r_skid_valid |-> r_main_valid)
    `SBPD_ASSERT(a_no_push_when_full, i_push |-> !r_skid_valid)
    `SBPD_ASSERT(a_drain_empties,
        w_pop && !r_skid_valid && !i_push |=> !r_main_valid)

endmodule

>>> dv/tb.sv
// Self-checking testbench for servo_bus_packet_deframer.
// Depends on sbpd_pkg and the sbpd_in_if / sbpd_out_if channels; predicts every
// result from the received byte stream and checks each one as it leaves o_out.
module tb;
    import sbpd_pkg::*;

    localparam int MAX_DATA      = 64;
    localparam int TARGET_BYTES  = 650;   // random part, counted from the queue
    localparam int CALM_TAIL     = 80;    // last transfers run without idling
    localparam int QUIET_LIMIT   = 500;   // cycles with no transfer at all
    localparam int SETTLE_CYCLES = 20;
    localparam int WHOLE_FRAME   = 1000;  // keep count that never cuts a frame
    localparam int REPORT_LIMIT  = 10;

    // Parser phases, in the order the frame fields arrive.
    typedef enum logic [2:0] {
        HUNT_FIRST, HUNT_SECOND, TAKE_LEN, TAKE_ID, TAKE_CMD, TAKE_CK1, TAKE_CK2,
        TAKE_DATA
    } t_phase;

    // One entry of the byte feed: either a byte to send or a hold marker that
    // stalls the sender until every predicted result has come out.
    typedef struct {
        bit         hold;
        logic [7:0] value;
    } t_feed;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sbpd_in_if  in_if ();
    sbpd_out_if out_if ();

    servo_bus_packet_deframer #(
        .MAX_DATA (MAX_DATA)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    t_feed   feed_q[$];
    t_result awaited_q[$];

    int fault_count  = 0;
    int src_idle     = 0;
    int sink_idle    = 0;
    int quiet_cycles = 0;
    bit in_fired     = 1'b0;

    // Predictor state, as the block holds it after reset.
    t_phase     phase    = HUNT_FIRST;
    logic [7:0] seen     = '0;
    logic [7:0] run_xor  = '0;
    logic [7:0] len_f    = '0;
    logic [7:0] id_f     = '0;
    logic [7:0] cmd_f    = '0;
    logic [7:0] ck1_f    = '0;
    logic [7:0] ck2_f    = '0;
    logic [7:0] pay_cnt  = '0;
    logic [7:0] prev_pay = '0;
    logic       ovf_seen = 1'b0;

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
    endtask

    // Fill the packet summary. Status bytes only when the closing byte is
    // payload and at least two payload bytes have been seen.
    function automatic void close_packet(inout t_result r, input bit have_data,
                                         input logic [7:0] last);
        logic [7:0] sum1;
        logic [7:0] sum2;
        sum1            = run_xor & CHK_MASK;
        sum2            = ~sum1 & CHK_MASK;
        r.packet_end    = 1'b1;
        r.packet_id     = id_f;
        r.command       = cmd_f;
        r.packet_size   = len_f;
        if (have_data && pay_cnt >= 8'd2) begin
            r.stat_err  = prev_pay;
            r.stat_info = last;
        end
        r.checksum_ok   = (sum1 == ck1_f) && (sum2 == ck2_f);
        r.data_overflow = ovf_seen;
    endfunction

    // Advance the predicted parser by one received byte; queue the result
    // that it causes, if any.
    task automatic deframe_byte(input logic [7:0] b);
        t_result r;
        bit      emit;
        r    = '0;
        emit = 1'b0;
        case (phase)
            HUNT_FIRST: begin
                if (b == HDR_BYTE) phase = HUNT_SECOND;
            end
            HUNT_SECOND: begin
                phase = (b == HDR_BYTE) ? TAKE_LEN : HUNT_FIRST;
            end
            TAKE_LEN: begin
                len_f = b;
                if (b < MIN_LEN) begin
                    // short length: lone error result, drop the packet
                    r.packet_size  = b;
                    r.length_error = 1'b1;
                    emit           = 1'b1;
                    phase          = HUNT_FIRST;
                end else begin
                    run_xor  = b;
                    seen     = 8'd3;
                    pay_cnt  = '0;
                    prev_pay = '0;
                    ovf_seen = 1'b0;
                    id_f     = '0;
                    cmd_f    = '0;
                    ck1_f    = '0;
                    ck2_f    = '0;
                    phase    = TAKE_ID;
                end
            end
            TAKE_ID: begin
                id_f    = b;
                run_xor = run_xor ^ b;
                seen    = seen + 8'd1;
                phase   = TAKE_CMD;
            end
            TAKE_CMD: begin
                cmd_f   = b;
                run_xor = run_xor ^ b;
                seen    = seen + 8'd1;
                phase   = TAKE_CK1;
            end
            TAKE_CK1: begin
                ck1_f = b;
                seen  = seen + 8'd1;
                phase = TAKE_CK2;
            end
            TAKE_CK2: begin
                ck2_f = b;
                seen  = seen + 8'd1;
                if (seen >= len_f) begin
                    // no payload: the second check byte closes the packet
                    close_packet(r, 1'b0, 8'h00);
                    emit  = 1'b1;
                    phase = HUNT_FIRST;
                end else begin
                    phase = TAKE_DATA;
                end
            end
            default: begin
                if (pay_cnt < MAX_DATA) begin
                    r.data_valid = 1'b1;
                    r.data_byte  = b;
                    r.data_index = pay_cnt[IDX_W-1:0];
                    emit         = 1'b1;
                end else begin
                    // beyond the store: no data result, but still summed
                    ovf_seen = 1'b1;
                end
                run_xor = run_xor ^ b;
                if (pay_cnt != 8'hFF) pay_cnt = pay_cnt + 8'd1;
                seen = seen + 8'd1;
                if (seen >= len_f) begin
                    close_packet(r, 1'b1, b);
                    emit  = 1'b1;
                    phase = HUNT_FIRST;
                end
                prev_pay = b;
            end
        endcase
        if (emit) awaited_q.push_back(r);
    endtask

    // Compare one delivered result, field by field, with the oldest prediction.
    task automatic check_result();
        t_result got;
        t_result want;
        string   bad;
        got = '{out_if.data_valid, out_if.data_byte, out_if.data_index,
                out_if.packet_end, out_if.packet_id, out_if.command,
                out_if.packet_size, out_if.stat_err, out_if.stat_info,
                out_if.checksum_ok, out_if.data_overflow, out_if.length_error};
        if (awaited_q.size() == 0) begin
            note_fault($sformatf("unexpected result %p", got));
        end else begin
            want = awaited_q.pop_front();
            bad  = "";
            if (got.data_valid    !== want.data_valid)    bad = {bad, " data_valid"};
            if (got.data_byte     !== want.data_byte)     bad = {bad, " data_byte"};
            if (got.data_index    !== want.data_index)    bad = {bad, " data_index"};
            if (got.packet_end    !== want.packet_end)    bad = {bad, " packet_end"};
            if (got.packet_id     !== want.packet_id)     bad = {bad, " packet_id"};
            if (got.command       !== want.command)       bad = {bad, " command"};
            if (got.packet_size   !== want.packet_size)   bad = {bad, " packet_size"};
            if (got.stat_err      !== want.stat_err)      bad = {bad, " stat_err"};
            if (got.stat_info     !== want.stat_info)     bad = {bad, " stat_info"};
            if (got.checksum_ok   !== want.checksum_ok)   bad = {bad, " checksum_ok"};
            if (got.data_overflow !== want.data_overflow) bad = {bad, " data_overflow"};
            if (got.length_error  !== want.length_error)  bad = {bad, " length_error"};
            if (bad != "") begin
                note_fault($sformatf("mismatch on%s: expected %p, got %p",
                                     bad, want, got));
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        feed_q.push_back('{1'b0, b});
    endtask

    task automatic push_hold();
        feed_q.push_back('{1'b1, 8'h00});
    endtask

    // Queue a frame: header, length and, for lengths of seven or more, id,
    // command, check bytes and random payload. A bad sum flips one checked bit
    // of one check byte; keep cuts the frame short after that many bytes.
    task automatic push_frame(input logic [7:0] len, input logic [7:0] id,
                              input logic [7:0] cmd, input bit good_sum,
                              input int keep);
        logic [7:0] frame[$];
        logic [7:0] payload[$];
        logic [7:0] sum;
        logic [7:0] ck1;
        logic [7:0] ck2;
        frame = '{HDR_BYTE, HDR_BYTE, len};
        if (len >= MIN_LEN) begin
            sum = len ^ id ^ cmd;
            for (int k = 7; k < int'(len); k++) begin
                payload.push_back(8'($urandom_range(0, 255)));
                sum = sum ^ payload[$];
            end
            ck1 = sum & CHK_MASK;
            ck2 = ~ck1 & CHK_MASK;
            if (!good_sum) begin
                if ($urandom_range(0, 1)) ck1 = ck1 ^ (8'h01 << $urandom_range(1, 7));
                else                      ck2 = ck2 ^ (8'h01 << $urandom_range(1, 7));
            end
            frame.push_back(id);
            frame.push_back(cmd);
            frame.push_back(ck1);
            frame.push_back(ck2);
            foreach (payload[k]) frame.push_back(payload[k]);
        end
        for (int k = 0; k < frame.size() && k < keep; k++) push_byte(frame[k]);
    endtask

    // Byte driver: change inputs on the falling edge. Hold the current byte
    // until its transfer, then idle in bursts, honour hold markers, or advance.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_fired) begin
            if (src_idle != 0) begin
                src_idle    <= src_idle - 1;
                in_if.valid <= 1'b0;
            end else if (feed_q.size() == 0) begin
                in_if.valid <= 1'b0;
            end else if (feed_q[0].hold) begin
                // pause until the block has delivered everything predicted
                in_if.valid <= 1'b0;
                if (awaited_q.size() == 0) void'(feed_q.pop_front());
            end else if (feed_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
                src_idle    <= $urandom_range(0, 8);
                in_if.valid <= 1'b0;
            end else begin
                in_if.valid   <= 1'b1;
                in_if.rx_byte <= feed_q[0].value;
                void'(feed_q.pop_front());
            end
        end
    end

    // Result receiver: stall in random bursts, never in the calm tail.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (sink_idle != 0) begin
            sink_idle    <= sink_idle - 1;
            out_if.ready <= 1'b0;
        end else if (feed_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            sink_idle    <= $urandom_range(0, 8);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Monitor: on the rising edge, predict from each byte transfer, check each
    // result transfer, and watch for a block that has stopped moving.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fired     <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            in_fired <= in_if.valid && in_if.ready;
            if (in_if.valid === 1'b1 && in_if.ready === 1'b1) deframe_byte(in_if.rx_byte);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) check_result();
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int frames;
        int pick;
        int directed;
        in_if.valid   = 1'b0;
        in_if.rx_byte = 8'h00;
        out_if.ready  = 1'b0;
        i_rst_n       = 1'b0;

        // Directed: zero and just-short lengths, a broken header, an empty
        // payload with extreme id and command, and a two-byte payload with a
        // bad check so that the status bytes and a failed verdict show up.
        push_frame(8'd0, 8'h00, 8'h00, 1'b1, WHOLE_FRAME);
        push_frame(8'd6, 8'h00, 8'h00, 1'b1, WHOLE_FRAME);
        push_byte(HDR_BYTE);
        push_byte(8'h12);
        push_frame(8'd7, 8'h00, 8'hFF, 1'b1, WHOLE_FRAME);
        push_frame(8'd9, 8'hFF, 8'h00, 1'b0, WHOLE_FRAME);
        push_hold();
        directed = feed_q.size();

        // Random: mostly well-formed frames with random content, one frame of
        // the largest length (overflows the store), one moderate overflow, and
        // a share of short lengths, broken headers, noise and cut-off frames.
        frames = 0;
        while (feed_q.size() < directed + TARGET_BYTES) begin
            frames++;
            if (frames == 6) begin
                push_frame(8'd255, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           1'b1, WHOLE_FRAME);
            end else if (frames == 25) begin
                push_hold();
            end else if (frames == 40) begin
                push_frame(8'($urandom_range(72, 130)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), $urandom_range(0, 1), WHOLE_FRAME);
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 65) begin
                    push_frame(8'($urandom_range(7, 20)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
                               WHOLE_FRAME);
                end else if (pick < 72) begin
                    push_frame(8'($urandom_range(21, 71)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
                               WHOLE_FRAME);
                end else if (pick < 79) begin
                    push_frame(8'($urandom_range(0, 6)), 8'h00, 8'h00, 1'b1, WHOLE_FRAME);
                end else if (pick < 86) begin
                    push_byte(HDR_BYTE);
                    push_byte(8'($urandom_range(0, 254)));
                end else if (pick < 94) begin
                    repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
                end else begin
                    // cut short: the next frame's bytes land in this payload
                    push_frame(8'($urandom_range(8, 30)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 1'b1, $urandom_range(3, 8));
                end
            end
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every byte transferred, every predicted result delivered,
        // then a short settle to catch stray results.
        while (feed_q.size() != 0 || in_if.valid) @(posedge i_clk);
        while (awaited_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (awaited_q.size() != 0) begin
            note_fault($sformatf("%0d results never delivered", awaited_q.size()));
        end

        if (fault_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
